### sv/skvt_pkg.sv
// Package for the sorted key/value table.
// Holds default sizes, action codes and the sequencer state type.
// No dependencies.
package skvt_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // Action codes carried on the input tuser
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_ACT,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } t_state;

endpackage

### sv/sorted_key_value_table.sv
// Sorted key/value table: fixed-capacity map held in one synchronous RAM of
// {value, key} words kept in ascending key order.
// Depends on skvt_pkg.
//
// Usage
//   Input stream (s_axis_*): one transaction per operation. tuser carries the
//   action (insert-or-update or lookup); tdata carries key then value.
//   Output stream (m_axis_*): exactly one transaction per operation, in order.
//   tdata carries the read value and the entry count after the operation;
//   tuser carries the found and full-drop flags.
// Timing
//   One operation at a time. Each one first runs a binary search over the
//   current count, each halving step a RAM read, then a compare. An insert of
//   a new key also moves every larger entry up one slot, one RAM read and one
//   write per cycle. The single RAM port pair sets this pace.
// Reset
//   i_rst_n (synchronous, active low) empties the table: the count goes to
//   zero. The RAM is not cleared; only entries below the count are read.
// Backpressure
//   A finished result sits in an output register. The next operation is
//   accepted while it waits; that operation holds in its final step until
//   the output register frees up.
module sorted_key_value_table #(
    parameter int CAPACITY   = skvt_pkg::CAPACITY,
    parameter int KEY_BITS   = skvt_pkg::KEY_BITS,
    parameter int VALUE_BITS = skvt_pkg::VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // tdata, low bit up: key, value, zero pad to bytes
    input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: action
    input  logic                                          s_axis_tuser,

    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // tdata, low bit up: read_value, entry_count, zero pad to bytes
    output logic [((VALUE_BITS + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser, low bit up: found, full_drop
    output logic [1:0]                                    m_axis_tuser
);

    localparam int IW    = $clog2(CAPACITY);        // RAM index width
    localparam int CW    = $clog2(CAPACITY + 1);    // count / position width
    localparam int WW    = KEY_BITS + VALUE_BITS;   // RAM word width
    localparam int OUT_W = ((VALUE_BITS + CW + 7) / 8) * 8;

    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [IW-1:0] IDX_ONE  = IW'(1);

    // ---------------------------------------------------------------
    // Pair RAM: word = {value, key}, one write and one read per cycle,
    // read data registered.
    // ---------------------------------------------------------------
    logic [WW-1:0] mem [CAPACITY];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [WW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    wire [KEY_BITS-1:0]   rd_key = r_rd_data[KEY_BITS-1:0];
    wire [VALUE_BITS-1:0] rd_val = r_rd_data[WW-1:KEY_BITS];

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    skvt_pkg::t_state r_state, n_state;

    logic                  r_action,  n_action;
    logic [KEY_BITS-1:0]   r_key,     n_key;
    logic [VALUE_BITS-1:0] r_value,   n_value;

    logic [CW-1:0]         r_count,   n_count;
    logic [CW-1:0]         r_lo,      n_lo;      // search window [lo, hi)
    logic [CW-1:0]         r_hi,      n_hi;
    logic [CW-1:0]         r_mid,     n_mid;
    logic                  r_eq,      n_eq;      // key at current hi matches
    logic [VALUE_BITS-1:0] r_hval,    n_hval;    // value at current hi
    logic [IW-1:0]         r_src,     n_src;     // entry being moved up

    // pending result
    logic                  r_res_found, n_res_found;
    logic                  r_res_drop,  n_res_drop;
    logic [VALUE_BITS-1:0] r_res_val,   n_res_val;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found, n_out_found;
    logic                  r_out_drop,  n_out_drop;
    logic [VALUE_BITS-1:0] r_out_val,   n_out_val;
    logic [CW-1:0]         r_out_cnt,   n_out_cnt;

    logic [CW-1:0] mid;
    logic [IW-1:0] pos_idx;

    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign pos_idx = r_lo[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skvt_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_key       <= n_key;
        r_value     <= n_value;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_eq        <= n_eq;
        r_hval      <= n_hval;
        r_src       <= n_src;
        r_res_found <= n_res_found;
        r_res_drop  <= n_res_drop;
        r_res_val   <= n_res_val;
        r_out_found <= n_out_found;
        r_out_drop  <= n_out_drop;
        r_out_val   <= n_out_val;
        r_out_cnt   <= n_out_cnt;
    end

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_key       = r_key;
        n_value     = r_value;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_eq        = r_eq;
        n_hval      = r_hval;
        n_src       = r_src;
        n_res_found = r_res_found;
        n_res_drop  = r_res_drop;
        n_res_val   = r_res_val;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_drop  = r_out_drop;
        n_out_val   = r_out_val;
        n_out_cnt   = r_out_cnt;

        mem_we    = 1'b0;
        mem_waddr = pos_idx;
        mem_wdata = {r_value, r_key};
        mem_re    = 1'b0;
        mem_raddr = mid[IW-1:0];

        s_axis_tready = 1'b0;

        // receiver takes the held result
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            skvt_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_action = s_axis_tuser;
                    n_key    = s_axis_tdata[KEY_BITS-1:0];
                    n_value  = s_axis_tdata[WW-1:KEY_BITS];
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_eq     = 1'b0;
                    n_state  = skvt_pkg::ST_RD;
                end
            end

            // issue the probe read, or finish when the window is empty
            skvt_pkg::ST_RD: begin
                if (r_lo < r_hi) begin
                    mem_re  = 1'b1;
                    n_mid   = mid;
                    n_state = skvt_pkg::ST_CMP;
                end else begin
                    n_state = skvt_pkg::ST_ACT;
                end
            end

            skvt_pkg::ST_CMP: begin
                if (rd_key < r_key) begin
                    n_lo = r_mid + CNT_ONE;
                end else begin
                    n_hi   = r_mid;
                    n_eq   = (rd_key == r_key);
                    n_hval = rd_val;
                end
                n_state = skvt_pkg::ST_RD;
            end

            // lo == hi is the insertion position; r_eq says hit there
            skvt_pkg::ST_ACT: begin
                n_res_found = r_eq;
                n_res_drop  = 1'b0;
                n_res_val   = '0;
                n_state     = skvt_pkg::ST_DONE;
                if (r_action == skvt_pkg::ACT_LOOKUP) begin
                    if (r_eq) begin
                        n_res_val = r_hval;
                    end
                end else if (r_eq) begin
                    mem_we = 1'b1;              // update in place
                end else if (r_count == CNT_FULL) begin
                    n_res_drop = 1'b1;
                end else if (r_lo != r_count) begin
                    // open a gap: start moving from the top entry down
                    mem_re    = 1'b1;
                    mem_raddr = IW'(r_count - CNT_ONE);
                    n_src     = IW'(r_count - CNT_ONE);
                    n_state   = skvt_pkg::ST_SHIFT;
                end else begin
                    n_state = skvt_pkg::ST_PLACE;
                end
            end

            // write entry src one slot up, read the next one below
            skvt_pkg::ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_src + IDX_ONE;
                mem_wdata = r_rd_data;
                if (r_src != pos_idx) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_src - IDX_ONE;
                    n_src     = r_src - IDX_ONE;
                end else begin
                    n_state = skvt_pkg::ST_PLACE;
                end
            end

            skvt_pkg::ST_PLACE: begin
                mem_we  = 1'b1;
                n_count = r_count + CNT_ONE;
                n_state = skvt_pkg::ST_DONE;
            end

            skvt_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_drop  = r_res_drop;
                    n_out_val   = r_res_val;
                    n_out_cnt   = r_count;
                    n_state     = skvt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = skvt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_cnt, r_out_val});
    assign m_axis_tuser  = {r_out_drop, r_out_found};

endmodule
